FILE: rtl/core/kslp_pkg.sv
// Shared constants and types for the short/long key press detector.
package kslp_pkg;

   // Width of the tick prescaler and the hold counter.
   localparam int COUNT_WIDTH = 8;
   // Width of the two limit registers.
   localparam int LIMIT_WIDTH = 8;
   // Common width used when a counter is compared with a limit.
   localparam int CMP_WIDTH = (COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH;
   localparam int CSR_INDEX_WIDTH = 1;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PRESCALE_LIMIT   = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_LONG_PRESS_LIMIT = 1'd1;

   // Reset values of the limit registers.
   localparam logic [LIMIT_WIDTH-1:0] PRESCALE_LIMIT_RESET   = 8'd5;
   localparam logic [LIMIT_WIDTH-1:0] LONG_PRESS_LIMIT_RESET = 8'd120;

   // Transaction kinds carried by the action field.
   localparam logic ACTION_TICK = 1'b0;
   localparam logic ACTION_READ = 1'b1;

   // Key event codes.
   localparam logic [1:0] EV_NONE  = 2'd0;
   localparam logic [1:0] EV_SHORT = 2'd1;
   localparam logic [1:0] EV_LONG  = 2'd2;

   // Configuration seen by the scan logic.
   typedef struct packed {
      logic [LIMIT_WIDTH-1:0] prescale_limit;
      logic [LIMIT_WIDTH-1:0] long_press_limit;
   } cfg_type;

   // Per-cycle control from the transaction stage to the scan logic.
   typedef struct packed {
      logic step;
      logic read;
      logic pressed;
   } scan_ctrl_type;

endpackage

FILE: rtl/core/kslp_scan.sv
// Tick prescaler, three-state key scan machine and latched key event.
module kslp_scan (
   input  logic                    clock,
   input  logic                    reset,
   input  kslp_pkg::cfg_type       cfg,
   input  kslp_pkg::scan_ctrl_type ctrl,
   output logic [1:0]              pending_event
);

   localparam int CW = kslp_pkg::CMP_WIDTH;
   localparam int NW = kslp_pkg::COUNT_WIDTH;

   typedef enum logic [1:0] {
      ST_CHECK,
      ST_CONFIRM,
      ST_RELEASE
   } scan_state_type;

   scan_state_type  state_ff, state_in;
   logic [NW-1:0]   tick_count_ff, tick_count_in;
   logic [NW-1:0]   hold_count_ff, hold_count_in;
   logic            confirmed_mark_ff, confirmed_mark_in;
   logic [1:0]      pending_event_ff, pending_event_in;

   logic [NW-1:0]   tick_sum;
   logic [NW-1:0]   hold_sum;
   logic            scan_run;

   // Prescaler: a scan runs once the incremented count passes the limit.
   assign tick_sum = tick_count_ff + NW'(1);
   assign hold_sum = hold_count_ff + NW'(1);
   assign scan_run = ctrl.step && (CW'(tick_sum) > CW'(cfg.prescale_limit));

   // Next-state logic for one tick or read transaction.
   always_comb begin
      state_in          = state_ff;
      tick_count_in     = tick_count_ff;
      hold_count_in     = hold_count_ff;
      confirmed_mark_in = confirmed_mark_ff;
      pending_event_in  = pending_event_ff;

      if (ctrl.read) begin
         pending_event_in = kslp_pkg::EV_NONE;
      end

      if (ctrl.step) begin
         tick_count_in = scan_run ? '0 : tick_sum;
      end

      if (scan_run) begin
         case (state_ff)
            ST_CHECK: begin
               if (ctrl.pressed) begin
                  state_in = ST_CONFIRM;
               end
               hold_count_in     = '0;
               confirmed_mark_in = 1'b0;
            end
            ST_CONFIRM: begin
               if (ctrl.pressed) begin
                  confirmed_mark_in = 1'b1;
                  hold_count_in     = hold_sum;
                  // Long press is reported while the key is still held.
                  if (CW'(hold_sum) > CW'(cfg.long_press_limit)) begin
                     pending_event_in  = kslp_pkg::EV_LONG;
                     hold_count_in     = '0;
                     confirmed_mark_in = 1'b0;
                     state_in          = ST_RELEASE;
                  end
               end else if (confirmed_mark_ff) begin
                  pending_event_in = kslp_pkg::EV_SHORT;
                  state_in         = ST_RELEASE;
               end else begin
                  // A press seen for one scan only is a glitch.
                  state_in = ST_CHECK;
               end
            end
            ST_RELEASE: begin
               if (!ctrl.pressed) begin
                  state_in = ST_CHECK;
               end
            end
            default: begin
               state_in = ST_CHECK;
            end
         endcase
      end
   end

   // State and event registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_CHECK;
         tick_count_ff     <= '0;
         hold_count_ff     <= '0;
         confirmed_mark_ff <= 1'b0;
         pending_event_ff  <= kslp_pkg::EV_NONE;
      end else begin
         state_ff          <= state_in;
         tick_count_ff     <= tick_count_in;
         hold_count_ff     <= hold_count_in;
         confirmed_mark_ff <= confirmed_mark_in;
         pending_event_ff  <= pending_event_in;
      end
   end

   assign pending_event = pending_event_ff;

   // A read always leaves no event behind.
   a_read_clears: assert property (@(posedge clock) disable iff (reset)
      ctrl.read |=> (pending_event_ff == kslp_pkg::EV_NONE))
      else $error("pending event not cleared by read");

   // The prescaler only moves on a tick transaction.
   a_tick_hold: assert property (@(posedge clock) disable iff (reset)
      !ctrl.step |=> $stable(tick_count_ff))
      else $error("tick count changed without a tick");

   // The event changes only through a tick or a read.
   a_event_hold: assert property (@(posedge clock) disable iff (reset)
      (!ctrl.step && !ctrl.read) |=> $stable(pending_event_ff))
      else $error("pending event changed without a transaction");

endmodule

FILE: rtl/core/key_short_long_press_detector.sv
// Top level of the debounced short/long key press detector.
// A read transaction's response is registered when the held read proceeds.
// One transaction per cycle unless a response is stalled; ticks give no response.
// The input register and the response register are each one stage deep.
// Reset is synchronous and active high; limits return to 5 and 120.
// After reset the scan is in its check state with no pending event.
module key_short_long_press_detector (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_action,
   input  logic                                   req_key_level,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [1:0]                             rsp_key_event,
   input  logic                                   csr_write_enable,
   input  logic [kslp_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [kslp_pkg::LIMIT_WIDTH-1:0]       csr_write_data
);

   kslp_pkg::cfg_type       cfg_ff;
   kslp_pkg::scan_ctrl_type ctrl;

   logic       in_valid_ff;
   logic       in_action_ff;
   logic       in_level_ff;
   logic       rsp_valid_ff;
   logic [1:0] rsp_key_event_ff;
   logic [1:0] pending_event;
   logic       out_free;
   logic       fire;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prescale_limit   <= kslp_pkg::PRESCALE_LIMIT_RESET;
         cfg_ff.long_press_limit <= kslp_pkg::LONG_PRESS_LIMIT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            kslp_pkg::REG_PRESCALE_LIMIT:   cfg_ff.prescale_limit   <= csr_write_data;
            kslp_pkg::REG_LONG_PRESS_LIMIT: cfg_ff.long_press_limit <= csr_write_data;
            default: ;
         endcase
      end
   end

   // The held transaction proceeds when the response register can take a result.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_action_ff <= req_action;
         in_level_ff  <= req_key_level;
      end
   end

   assign ctrl.step    = fire && (in_action_ff == kslp_pkg::ACTION_TICK);
   assign ctrl.read    = fire && (in_action_ff == kslp_pkg::ACTION_READ);
   assign ctrl.pressed = !in_level_ff;

   kslp_scan u_scan (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .ctrl          (ctrl),
      .pending_event (pending_event)
   );

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= ctrl.read;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.read) begin
         rsp_key_event_ff <= pending_event;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_key_event = rsp_key_event_ff;

   // A response appears only after a read transaction was processed.
   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctrl.read))
      else $error("response without a read");

   // The unused event code never reaches the response.
   a_rsp_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_key_event_ff != 2'd3))
      else $error("invalid key event code");

endmodule

FILE: test/tb_key_short_long_press_detector.sv
// Self-checking testbench for the short/long key press detector.
module tb_key_short_long_press_detector;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned WATCHDOG_CYCLES       = 200000;
   localparam int unsigned DRAIN_CYCLES          = 8;
   localparam int unsigned RANDOM_ITEMS_PER_PASS = 80;
   localparam int unsigned MAX_REPORTED          = 10;

   // Scan states of the debounce machine as the predictor tracks them.
   typedef enum logic [1:0] {
      SCAN_CHECK   = 2'd0,
      SCAN_CONFIRM = 2'd1,
      SCAN_RELEASE = 2'd2
   } scan_phase_type;

   logic                                 clock            = 1'b0;
   logic                                 reset            = 1'b1;
   logic                                 req_valid        = 1'b0;
   logic                                 req_ready;
   logic                                 req_action       = kslp_pkg::ACTION_TICK;
   logic                                 req_key_level    = 1'b1;
   logic                                 rsp_valid;
   logic                                 rsp_ready        = 1'b0;
   logic [1:0]                           rsp_key_event;
   logic                                 csr_write_enable = 1'b0;
   logic [kslp_pkg::CSR_INDEX_WIDTH-1:0] csr_index        = kslp_pkg::REG_PRESCALE_LIMIT;
   logic [kslp_pkg::LIMIT_WIDTH-1:0]     csr_write_data   = '0;

   // Idle rates of the two channels, in percent of cycles.
   int unsigned send_idle_pct = 33;
   int unsigned recv_idle_pct = 58;
   int unsigned items_sent    = 0;
   int unsigned fail_count    = 0;
   int unsigned cycle_count   = 0;

   // Key events that reads are due to return, oldest first.
   logic [1:0] key_events_due[$];

   // Predicted state of the detector and its limits.
   logic [kslp_pkg::LIMIT_WIDTH-1:0] prescale_cfg  = kslp_pkg::PRESCALE_LIMIT_RESET;
   logic [kslp_pkg::LIMIT_WIDTH-1:0] long_cfg      = kslp_pkg::LONG_PRESS_LIMIT_RESET;
   logic [kslp_pkg::COUNT_WIDTH-1:0] tick_cnt      = '0;
   logic [kslp_pkg::COUNT_WIDTH-1:0] hold_cnt      = '0;
   logic                             held_mark     = 1'b0;
   logic [1:0]                       latched_event = kslp_pkg::EV_NONE;
   scan_phase_type                   scan_phase    = SCAN_CHECK;

   key_short_long_press_detector DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_key_level    (req_key_level),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_key_event    (rsp_key_event),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // The receiver stalls at random, changing only on the falling edge.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Advance the predicted detector by one accepted transaction.
   task automatic predict_key_item(input logic action, input logic level);
      logic pressed;
      pressed = (level == 1'b0);
      if (action == kslp_pkg::ACTION_READ) begin
         key_events_due.push_back(latched_event);
         latched_event = kslp_pkg::EV_NONE;
      end else begin
         tick_cnt = tick_cnt + 1'b1;
         if (tick_cnt > prescale_cfg) begin
            tick_cnt = '0;
            case (scan_phase)
               SCAN_CHECK: begin
                  if (pressed) scan_phase = SCAN_CONFIRM;
                  hold_cnt  = '0;
                  held_mark = 1'b0;
               end
               SCAN_CONFIRM: begin
                  if (pressed) begin
                     held_mark = 1'b1;
                     hold_cnt  = hold_cnt + 1'b1;
                     // A long press is reported while the key is still held.
                     if (hold_cnt > long_cfg) begin
                        latched_event = kslp_pkg::EV_LONG;
                        hold_cnt      = '0;
                        held_mark     = 1'b0;
                        scan_phase    = SCAN_RELEASE;
                     end
                  end else if (held_mark) begin
                     latched_event = kslp_pkg::EV_SHORT;
                     scan_phase    = SCAN_RELEASE;
                  end else begin
                     // A press seen for one scan only is a glitch.
                     scan_phase = SCAN_CHECK;
                  end
               end
               SCAN_RELEASE: begin
                  if (!pressed) scan_phase = SCAN_CHECK;
               end
               default: begin
                  scan_phase = SCAN_CHECK;
               end
            endcase
         end
      end
   endtask

   // Send one transaction, idling at random before it.
   task automatic send_item(input logic action, input logic level);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid     = 1'b0;
         req_action    = 1'($urandom_range(1));
         req_key_level = 1'($urandom_range(1));
         @(negedge clock);
      end
      req_valid     = 1'b1;
      req_action    = action;
      req_key_level = level;
      do @(posedge clock); while (!req_ready);
      predict_key_item(action, level);
      items_sent++;
   endtask

   task automatic send_ticks(input int unsigned count, input logic level);
      for (int unsigned i = 0; i < count; i++) begin
         send_item(kslp_pkg::ACTION_TICK, level);
      end
   endtask

   // Drop valid, wait for every due event, then let in-flight ticks settle.
   task automatic wait_until_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (key_events_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Write one limit register while the detector is idle.
   task automatic write_limit(input logic [kslp_pkg::CSR_INDEX_WIDTH-1:0] index,
                              input logic [kslp_pkg::LIMIT_WIDTH-1:0] value);
      wait_until_idle();
      csr_write_enable = 1'b1;
      csr_index        = index;
      csr_write_data   = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      case (index)
         kslp_pkg::REG_PRESCALE_LIMIT:   prescale_cfg = value;
         kslp_pkg::REG_LONG_PRESS_LIMIT: long_cfg     = value;
         default: ;
      endcase
   endtask

   // Reads at reset, a glitch, a short press, a long press, an overwritten
   // event and a zero long limit, one scan per tick.
   task automatic test_directed();
      send_item(kslp_pkg::ACTION_READ, 1'b1);
      send_item(kslp_pkg::ACTION_READ, 1'b0);
      write_limit(kslp_pkg::REG_PRESCALE_LIMIT, 8'd0);
      write_limit(kslp_pkg::REG_LONG_PRESS_LIMIT, 8'd2);
      // Glitch: pressed for a single scan.
      send_ticks(1, 1'b0);
      send_ticks(1, 1'b1);
      send_item(kslp_pkg::ACTION_READ, 1'b1);
      // Short press, then a second read that finds the event cleared.
      send_ticks(2, 1'b0);
      send_ticks(2, 1'b1);
      send_item(kslp_pkg::ACTION_READ, 1'b0);
      send_item(kslp_pkg::ACTION_READ, 1'b1);
      // Long press left unread, then replaced by a short press.
      send_ticks(4, 1'b0);
      send_ticks(1, 1'b1);
      send_ticks(2, 1'b0);
      send_ticks(2, 1'b1);
      send_item(kslp_pkg::ACTION_READ, 1'b1);
      // With a zero long limit the first confirmed scan reports long.
      write_limit(kslp_pkg::REG_LONG_PRESS_LIMIT, 8'd0);
      send_ticks(2, 1'b0);
      send_ticks(1, 1'b1);
      send_item(kslp_pkg::ACTION_READ, 1'b1);
   endtask

   // Limits at or near the tops of their counters; at 255 the prescale comparison never holds.
   task automatic test_limit_extremes();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      // The prescaler wraps without ever running a scan.
      write_limit(kslp_pkg::REG_PRESCALE_LIMIT, 8'd255);
      write_limit(kslp_pkg::REG_LONG_PRESS_LIMIT, 8'd254);
      send_ticks(257, 1'b0);
      send_item(kslp_pkg::ACTION_READ, 1'b1);
      // A long limit near the top leaves a brief press as a short one.
      write_limit(kslp_pkg::REG_PRESCALE_LIMIT, 8'd0);
      send_ticks(3, 1'b0);
      send_ticks(2, 1'b1);
      send_item(kslp_pkg::ACTION_READ, 1'b0);
   endtask

   // Mostly whole presses of random length with bounces, the rest noise.
   task automatic test_random_presses(input int unsigned send_pct, input int unsigned recv_pct);
      int unsigned stop_at;
      int unsigned scan_ticks;
      int unsigned press_len;
      int unsigned count;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      write_limit(kslp_pkg::REG_PRESCALE_LIMIT, 8'($urandom_range(3)));
      write_limit(kslp_pkg::REG_LONG_PRESS_LIMIT, 8'($urandom_range(6)));
      stop_at = items_sent + RANDOM_ITEMS_PER_PASS;
      while (items_sent < stop_at) begin
         if ($urandom_range(4) == 0) begin
            count = $urandom_range(8, 1);
            for (int unsigned i = 0; i < count; i++) begin
               if ($urandom_range(4) == 0) begin
                  send_item(kslp_pkg::ACTION_READ, 1'($urandom_range(1)));
               end else begin
                  send_item(kslp_pkg::ACTION_TICK, 1'($urandom_range(1)));
               end
            end
         end else begin
            scan_ticks = prescale_cfg + 1;
            press_len  = $urandom_range(scan_ticks * (long_cfg + 3), 1);
            for (int unsigned i = 0; i < press_len; i++) begin
               if ($urandom_range(15) == 0) begin
                  send_item(kslp_pkg::ACTION_READ, 1'($urandom_range(1)));
               end
               send_item(kslp_pkg::ACTION_TICK, $urandom_range(19) == 0);
            end
            send_ticks($urandom_range(scan_ticks * 3, scan_ticks), 1'b1);
            if ($urandom_range(3) != 0) begin
               send_item(kslp_pkg::ACTION_READ, 1'($urandom_range(1)));
            end
         end
      end
   endtask

   // Compare each response transaction with the oldest due event.
   always @(posedge clock) begin : check_responses
      logic [1:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (key_events_due.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTED)
               $display("ERROR %0t: unexpected response, key_event %0d",
                        $time, rsp_key_event);
         end else begin
            want = key_events_due.pop_front();
            if (rsp_key_event !== want) begin
               fail_count++;
               if (fail_count <= MAX_REPORTED)
                  $display("ERROR %0t: key_event expected %0d, got %0d",
                           $time, want, rsp_key_event);
            end
         end
      end
   end

   // Stop a hung run.
   initial begin
      while (cycle_count < WATCHDOG_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** key_short_long_press_detector: FAILED **");
      $finish;
   end

   initial begin
      repeat (4) @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random_presses(33, 58);
      test_random_presses(58, 33);
      test_limit_extremes();
      test_random_presses(0, 0);
      wait_until_idle();
      if (fail_count == 0 && key_events_due.size() == 0) begin
         $display("** key_short_long_press_detector: PASSED **");
      end else begin
         $display("** key_short_long_press_detector: FAILED **");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/kslp_pkg.sv
rtl/core/kslp_scan.sv
rtl/core/key_short_long_press_detector.sv
test/tb_key_short_long_press_detector.sv
